// File: hdl/lz4_sequence_index_parser_macros.svh
// Assertion macros for the LZ4 sequence index parser.
// Depends on nothing; included by the modules that carry assertions.
`ifndef LZ4_SEQUENCE_INDEX_PARSER_MACROS_SVH
`define LZ4_SEQUENCE_INDEX_PARSER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LZ4SIP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define LZ4SIP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/lz4sip_pkg.sv
// Types and constants shared by the LZ4 sequence index parser.
// No dependencies.
package lz4sip_pkg;

	localparam int OUT_W  = 32;
	localparam int DIST_W = 16;
	localparam int LEN_W  = 32;

	// Token nibble value that announces extension bytes
	localparam logic [3:0] NIB_EXT = 4'hF;
	// Extension byte value that continues the length
	localparam logic [7:0] BYTE_EXT_CONT = 8'd255;
	// Minimum match length added to the token's match nibble
	localparam logic [LEN_W-1:0] MATCH_MIN = 32'd4;
	// Literal length carried by a saturated token nibble
	localparam logic [LEN_W-1:0] LIT_NIB_MAX = 32'd15;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       block_last;
	} byte_item_t;

	typedef struct packed {
		logic              literal_mark;
		logic              record_valid;
		logic              record_final;
		logic [OUT_W-1:0]  match_start;
		logic [OUT_W-1:0]  match_end;
		logic [DIST_W-1:0] match_distance;
	} rec_item_t;

	typedef enum logic [5:0] {
		PH_TOKEN     = 6'b000001,
		PH_LIT_EXT   = 6'b000010,
		PH_LITERALS  = 6'b000100,
		PH_OFF_LO    = 6'b001000,
		PH_OFF_HI    = 6'b010000,
		PH_MATCH_EXT = 6'b100000
	} phase_t;

endpackage

// File: hdl/lz4sip_stream_if.sv
// Valid/ready stream channel with a typed payload.
// Depends on nothing; payload type is given per instance.
interface lz4sip_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: hdl/lz4_sequence_index_parser.sv
// Top level of the LZ4 sequence index parser.
// Depends on lz4sip_pkg, lz4sip_stream_if, lz4sip_in_stage and lz4sip_parse.
//
// Usage:
//   byte_ch carries one compressed block byte per transfer with a last-of-block
//   flag. rec_ch returns exactly one result per input byte: the literal mark
//   for that byte, and a match or block-end record when one completes.
//   Path: a transferred byte is held in the input register, parsed from there
//   into the result register, and its result is offered on rec_ch from the
//   result register.
//   Throughput: one byte per cycle while rec_ch accepts results, set by the
//   phase decode and the saturating position adder between the two registers.
//   Stall: while rec_ch is held off, one result waits in the result register
//   and one byte in the input register; byte_ch drops ready only when both
//   are full, and no result is lost or repeated.
//   Reset (arst_n low): parser expects a token, output position and length
//   state clear, both registers empty.
//   The output position is POS_BITS wide, saturates at its maximum and is
//   reported as its low 32 bits.
module lz4_sequence_index_parser #(
	parameter int POS_BITS = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	lz4sip_stream_if.sink   byte_ch,
	lz4sip_stream_if.source rec_ch
);

	lz4sip_stream_if #(.T(lz4sip_pkg::byte_item_t)) item_ch ();

	// Register incoming bytes
	lz4sip_in_stage u_in_stage (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_ch (byte_ch),
		.item_ch (item_ch)
	);

	// Parse and register results
	lz4sip_parse #(
		.POS_BITS (POS_BITS)
	) u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.item_ch (item_ch),
		.rec_ch  (rec_ch)
	);

endmodule

// File: hdl/lz4sip_in_stage.sv
// Input register stage of the LZ4 sequence index parser.
// Depends on lz4sip_stream_if.
module lz4sip_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	lz4sip_stream_if.sink   byte_ch,
	lz4sip_stream_if.source item_ch
);

	logic valid_s1;

	// Take a new byte whenever the stage is empty or drains this cycle
	assign byte_ch.ready = !valid_s1 || item_ch.ready;
	assign item_ch.valid = valid_s1;

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ch.ready) begin
			valid_s1 <= byte_ch.valid;
		end
	end

	// Hold payload; load on each input transfer
	always_ff @(posedge clk) begin
		if (byte_ch.valid && byte_ch.ready) begin
			item_ch.payload <= byte_ch.payload;
		end
	end

endmodule

// File: hdl/lz4sip_parse.sv
// Sequence parser state and result register of the LZ4 sequence index parser.
// Depends on lz4sip_pkg, lz4sip_stream_if and the assertion macro header.
`include "lz4_sequence_index_parser_macros.svh"

module lz4sip_parse #(
	parameter int POS_BITS = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	lz4sip_stream_if.sink   item_ch,
	lz4sip_stream_if.source rec_ch
);

	// Sum width: wide enough for a position plus a 32-bit length, with carry
	localparam int SW = ((POS_BITS > lz4sip_pkg::LEN_W) ? POS_BITS : lz4sip_pkg::LEN_W) + 1;

	// Saturating position add
	function automatic logic [POS_BITS-1:0] pos_add(
		input logic [POS_BITS-1:0]          a,
		input logic [lz4sip_pkg::LEN_W-1:0] b
	);
		logic [SW-1:0] s;
		s = SW'(a) + SW'(b);
		if (s[SW-1:POS_BITS] != '0) begin
			return '1;
		end
		return s[POS_BITS-1:0];
	endfunction

	// Saturating length add
	function automatic logic [lz4sip_pkg::LEN_W-1:0] len_add(
		input logic [lz4sip_pkg::LEN_W-1:0] a,
		input logic [7:0]                   b
	);
		logic [lz4sip_pkg::LEN_W:0] s;
		s = {1'b0, a} + (lz4sip_pkg::LEN_W + 1)'(b);
		if (s[lz4sip_pkg::LEN_W]) begin
			return '1;
		end
		return s[lz4sip_pkg::LEN_W-1:0];
	endfunction

	// Report a position on the 32-bit output
	function automatic logic [lz4sip_pkg::OUT_W-1:0] to_out(input logic [POS_BITS-1:0] p);
		logic [SW-1:0] e;
		e = SW'(p);
		return e[lz4sip_pkg::OUT_W-1:0];
	endfunction

	lz4sip_pkg::phase_t                     phase_q, phase_d;
	logic [7:0]                             tok_q, tok_d;
	logic [lz4sip_pkg::LEN_W-1:0]           acc_q, acc_d;
	logic [lz4sip_pkg::LEN_W-1:0]           lits_q, lits_d;
	logic [7:0]                             offlo_q, offlo_d;
	logic [POS_BITS-1:0]                    pos_q, pos_d;
	logic [lz4sip_pkg::DIST_W-1:0]          dist_q, dist_d;

	logic                                   rec_valid_q;
	lz4sip_pkg::rec_item_t                  rec_q, res;

	logic                                   adv;
	logic [7:0]                             b;
	logic                                   last;
	logic                                   known, match;
	logic [lz4sip_pkg::LEN_W-1:0]           known_len, mlen, acc_sum, lits_dec, add_len;
	logic [lz4sip_pkg::DIST_W-1:0]          mdist, off_full;
	logic [POS_BITS-1:0]                    pos_next, pos_mend;

	assign item_ch.ready  = !rec_valid_q || rec_ch.ready;
	assign adv            = item_ch.valid && item_ch.ready;
	assign b              = item_ch.payload.byte_value;
	assign last           = item_ch.payload.block_last;
	assign rec_ch.valid   = rec_valid_q;
	assign rec_ch.payload = rec_q;

	assign acc_sum  = len_add(acc_q, b);
	assign lits_dec = lits_q - lz4sip_pkg::LEN_W'(lits_q != '0);
	assign off_full = {b, offlo_q};

	// Position after the literal run or match, and the match's last byte
	assign add_len  = known ? known_len : (match ? mlen : '0);
	assign pos_next = pos_add(pos_q, add_len);
	assign pos_mend = pos_add(pos_q, mlen - lz4sip_pkg::LEN_W'(1));

	// Decode one byte against the current phase
	always_comb begin
		phase_d   = phase_q;
		tok_d     = tok_q;
		acc_d     = acc_q;
		lits_d    = lits_q;
		offlo_d   = offlo_q;
		pos_d     = pos_q;
		dist_d    = dist_q;
		known     = 1'b0;
		known_len = '0;
		match     = 1'b0;
		mlen      = lz4sip_pkg::MATCH_MIN;
		mdist     = dist_q;
		res       = '0;

		unique case (phase_q)
			lz4sip_pkg::PH_LIT_EXT: begin
				acc_d = acc_sum;
				if (b != lz4sip_pkg::BYTE_EXT_CONT || last) begin
					known     = 1'b1;
					known_len = acc_sum;
				end
			end
			lz4sip_pkg::PH_LITERALS: begin
				res.literal_mark = 1'b1;
				lits_d = lits_dec;
				if (lits_dec == '0) begin
					phase_d = lz4sip_pkg::PH_OFF_LO;
				end
			end
			lz4sip_pkg::PH_OFF_LO: begin
				offlo_d = b;
				phase_d = lz4sip_pkg::PH_OFF_HI;
			end
			lz4sip_pkg::PH_OFF_HI: begin
				dist_d = off_full;
				if (tok_q[3:0] == lz4sip_pkg::NIB_EXT) begin
					acc_d   = lz4sip_pkg::LEN_W'(tok_q[3:0]) + lz4sip_pkg::MATCH_MIN;
					phase_d = lz4sip_pkg::PH_MATCH_EXT;
				end else begin
					match = 1'b1;
					mlen  = lz4sip_pkg::LEN_W'(tok_q[3:0]) + lz4sip_pkg::MATCH_MIN;
					mdist = off_full;
				end
			end
			lz4sip_pkg::PH_MATCH_EXT: begin
				acc_d = acc_sum;
				if (b != lz4sip_pkg::BYTE_EXT_CONT) begin
					match = 1'b1;
					mlen  = acc_sum;
				end
			end
			default: begin
				tok_d = b;
				if (b[7:4] == lz4sip_pkg::NIB_EXT) begin
					acc_d   = lz4sip_pkg::LIT_NIB_MAX;
					phase_d = lz4sip_pkg::PH_LIT_EXT;
					if (last) begin
						known     = 1'b1;
						known_len = lz4sip_pkg::LIT_NIB_MAX;
					end
				end else begin
					known     = 1'b1;
					known_len = lz4sip_pkg::LEN_W'(b[7:4]);
				end
			end
		endcase

		// Literal length complete: advance position, pick next phase
		if (known) begin
			pos_d   = pos_next;
			lits_d  = known_len;
			phase_d = (known_len != '0) ? lz4sip_pkg::PH_LITERALS : lz4sip_pkg::PH_OFF_LO;
		end

		// Match complete: emit its record and advance position
		if (match) begin
			res.record_valid   = 1'b1;
			res.match_start    = to_out(pos_q);
			res.match_end      = to_out(pos_mend);
			res.match_distance = mdist;
			pos_d              = pos_next;
			phase_d            = lz4sip_pkg::PH_TOKEN;
		end

		// Block end: emit the final record unless a match took the slot
		if (last) begin
			if (!match) begin
				res.record_valid = 1'b1;
				res.record_final = 1'b1;
				res.match_start  = to_out(pos_d);
				res.match_end    = to_out(pos_d);
			end
			phase_d = lz4sip_pkg::PH_TOKEN;
			acc_d   = '0;
			lits_d  = '0;
		end
	end

	// Advance parser state on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lz4sip_pkg::PH_TOKEN;
			tok_q   <= '0;
			acc_q   <= '0;
			lits_q  <= '0;
			offlo_q <= '0;
			pos_q   <= '0;
			dist_q  <= '0;
		end else if (adv) begin
			phase_q <= phase_d;
			tok_q   <= tok_d;
			acc_q   <= acc_d;
			lits_q  <= lits_d;
			offlo_q <= offlo_d;
			pos_q   <= pos_d;
			dist_q  <= dist_d;
		end
	end

	// Result register occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_valid_q <= 1'b0;
		end else if (item_ch.ready) begin
			rec_valid_q <= item_ch.valid;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (adv) begin
			rec_q <= res;
		end
	end

	`LZ4SIP_ASSERT_NEXT(a_last_resets_phase, clk, arst_n, adv && last,
		phase_q == lz4sip_pkg::PH_TOKEN && acc_q == '0 && lits_q == '0,
		"parser not back at token after block end")
	`LZ4SIP_ASSERT_NEXT(a_pos_monotonic, clk, arst_n, adv, pos_q >= $past(pos_q),
		"output position moved backward")
	`LZ4SIP_ASSERT_IMP(a_literals_pending, clk, arst_n, phase_q == lz4sip_pkg::PH_LITERALS,
		lits_q != '0, "literal phase with no literals left")

endmodule
